>>> hw/rtl/ssrl_pkg.sv
// Shared types and constants for the sorted symbol range lookup unit.
`default_nettype none

package ssrl_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned TABLE_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SORT   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // One table row: start address and the name reference that travels with it.
  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] name;
  } entry_t;

  // Flags from the shared compare/subtract unit.
  typedef struct packed {
    logic a_ge_b;
    logic a_lt_c;
  } alu_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/ssrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssrl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/ssrl_alu.sv
// Shared compare and subtract unit used by both the lookup scan and the sort passes.
`default_nettype none

module ssrl_alu
  import ssrl_pkg::*;
(
  input  wire logic [DATA_W-1:0] a_i,
  input  wire logic [DATA_W-1:0] b_i,
  input  wire logic [DATA_W-1:0] c_i,
  output alu_flags_t             flags_o,
  output logic      [DATA_W-1:0] diff_o
);

  logic [DATA_W:0] sub_ab;

  // One wide subtract gives both a >= b (no borrow) and the offset.
  assign sub_ab         = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o         = sub_ab[DATA_W-1:0];
  assign flags_o.a_ge_b = ~sub_ab[DATA_W];
  assign flags_o.a_lt_c = (a_i < c_i);

endmodule

`default_nettype wire

>>> hw/rtl/sorted_symbol_range_lookup_unit.sv
// Top level: command sequencer around the entry RAM and the shared compare unit.
// Insert and clear, and sort or lookup on fewer than two entries, strobe done
//   straight from idle; a lookup over N entries reads the RAM once per entry scanned,
//   and a sort makes bubble passes over L entries, L from N down to 2.
// Throughput: one command at a time, busy_o high until the result beat, which
//   cannot be stalled. Reset clears the entry count and sequencer, not the table.
`default_nettype none

module sorted_symbol_range_lookup_unit
  import ssrl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [DATA_W-1:0] address_i,
  input  wire logic [DATA_W-1:0] name_ref_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [DATA_W-1:0]      found_name_o,
  output logic [DATA_W-1:0]      offset_o
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LK_LOAD,
    S_LK_SCAN,
    S_SRT_LOAD,
    S_SRT_SCAN,
    S_SRT_TAIL
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;   // valid entries
  logic [CNT_W-1:0]  lim_q;     // entries in the current scan or sort pass
  logic [CNT_W-1:0]  idx_q;     // entry index being requested from the RAM
  entry_t            hold_q;    // previous entry (lookup) or bubbling entry (sort)
  logic [DATA_W-1:0] address_q;
  logic              done_q;
  status_e           status_q;
  logic [DATA_W-1:0] found_q;
  logic [DATA_W-1:0] offset_q;

  logic              accept;
  action_e           action;
  logic [CNT_W-1:0]  idx_m1;
  logic [CNT_W-1:0]  idx_m2;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_rdata;

  // Shared unit
  logic [DATA_W-1:0] alu_a;
  logic [DATA_W-1:0] alu_b;
  logic [DATA_W-1:0] alu_c;
  alu_flags_t        alu_flags;
  logic [DATA_W-1:0] alu_diff;

  logic              lk_hit;
  logic              srt_swap;

  assign accept = start_i && (state_q == S_IDLE);
  assign action = action_e'(action_i);
  assign idx_m1 = idx_q - CNT_ONE;
  assign idx_m2 = idx_q - CNT_TWO;

  // Lookup: address in [prev.start, cur.start). Sort: next.start < bubbling.start
  // moves the next entry down, which keeps equal starts in stored order.
  assign lk_hit   = alu_flags.a_ge_b && alu_flags.a_lt_c;
  assign srt_swap = alu_flags.a_lt_c;

  ssrl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ssrl_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .c_i     (alu_c),
    .flags_o (alu_flags),
    .diff_o  (alu_diff)
  );

  // RAM port and shared-unit operand steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = '{start: address_i, name: name_ref_i};
    ram_raddr = '0;
    alu_a     = address_q;
    alu_b     = hold_q.start;
    alu_c     = ram_rdata.start;
    unique case (state_q)
      S_IDLE: begin
        // Entry 0 is prefetched while idle so a scan can start at once.
        ram_we = accept && (action == ACT_INSERT) && (count_q != CNT_FULL);
      end
      S_LK_LOAD, S_LK_SCAN, S_SRT_LOAD: begin
        ram_raddr = idx_q[AW-1:0];
      end
      S_SRT_SCAN: begin
        ram_raddr = idx_q[AW-1:0];
        alu_a     = ram_rdata.start;
        alu_c     = hold_q.start;
        ram_we    = 1'b1;
        ram_waddr = idx_m2[AW-1:0];
        ram_wdata = srt_swap ? ram_rdata : hold_q;
      end
      S_SRT_TAIL: begin
        // Bubbling entry settles at the top of the pass; entry 0 refetched.
        ram_we    = 1'b1;
        ram_waddr = idx_m1[AW-1:0];
        ram_wdata = hold_q;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, counters and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      lim_q     <= '0;
      idx_q     <= '0;
      hold_q    <= '0;
      address_q <= '0;
      done_q    <= 1'b0;
      status_q  <= ST_OK;
      found_q   <= '0;
      offset_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q  <= ST_OK;
            found_q   <= '0;
            offset_q  <= '0;
            lim_q     <= count_q;
            idx_q     <= CNT_ONE;
            address_q <= address_i;
            unique case (action)
              ACT_INSERT: begin
                done_q <= 1'b1;
                if (count_q == CNT_FULL) begin
                  status_q <= ST_FULL;
                end else begin
                  count_q <= count_q + CNT_ONE;
                end
              end
              ACT_SORT: begin
                if (count_q < CNT_TWO) begin
                  done_q <= 1'b1;
                end else begin
                  state_q <= S_SRT_LOAD;
                end
              end
              ACT_LOOKUP: begin
                if (count_q < CNT_TWO) begin
                  done_q   <= 1'b1;
                  status_q <= ST_MISS;
                end else begin
                  state_q <= S_LK_LOAD;
                end
              end
              ACT_CLEAR: begin
                done_q  <= 1'b1;
                count_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_LK_LOAD: begin
          hold_q  <= ram_rdata;
          idx_q   <= idx_q + CNT_ONE;
          state_q <= S_LK_SCAN;
        end
        S_LK_SCAN: begin
          // ram_rdata is entry idx-1, hold_q is entry idx-2
          if (lk_hit) begin
            done_q   <= 1'b1;
            status_q <= ST_OK;
            found_q  <= hold_q.name;
            offset_q <= alu_diff;
            state_q  <= S_IDLE;
          end else if (idx_q == lim_q) begin
            done_q   <= 1'b1;
            status_q <= ST_MISS;
            state_q  <= S_IDLE;
          end else begin
            hold_q <= ram_rdata;
            idx_q  <= idx_q + CNT_ONE;
          end
        end
        S_SRT_LOAD: begin
          hold_q  <= ram_rdata;
          idx_q   <= idx_q + CNT_ONE;
          state_q <= S_SRT_SCAN;
        end
        S_SRT_SCAN: begin
          if (!srt_swap) begin
            hold_q <= ram_rdata;
          end
          if (idx_q == lim_q) begin
            state_q <= S_SRT_TAIL;
          end else begin
            idx_q <= idx_q + CNT_ONE;
          end
        end
        S_SRT_TAIL: begin
          if (lim_q > CNT_TWO) begin
            lim_q   <= lim_q - CNT_ONE;
            idx_q   <= CNT_ONE;
            state_q <= S_SRT_LOAD;
          end else begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign found_name_o = found_q;
  assign offset_o     = offset_q;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the sorted symbol range lookup unit.
module tb_top
  import ssrl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock and run length. The cycle limit is several times the slowest correct
  // run of this stimulus: full-table sorts, full lookup walks and idle gaps
  // between beats.
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_BEATS = 1850;
  localparam int QUIET_BEATS  = 200;       // final stretch driven back to back
  localparam int TAIL_CYCLES  = 80;        // longer than one full lookup walk
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int MAX_REPORTS  = 10;
  localparam int DEPTH        = TABLE_DEPTH_DEF;

  // Expected answer of one command.
  typedef struct packed {
    status_e          status;
    logic [DATA_W-1:0] name;
    logic [DATA_W-1:0] offset;
  } symbol_answer_t;

  // Directed row: command plus, where typed, the answer it must give.
  typedef struct packed {
    action_e           act;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] name;
    logic              typed;
    status_e           status;
    logic [DATA_W-1:0] found;
    logic [DATA_W-1:0] offset;
  } directed_row_t;

  localparam int DIRECTED_N = 23;

  // Walks the special cases: empty and one-entry tables, the address
  // extremes, inclusive start, exclusive end, unsorted scan, equal starts
  // (empty range), clear, and sort of an empty table.
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_MISS, 32'h0, 32'h0},
    '{ACT_SORT,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_OK,   32'h0, 32'h0},
    '{ACT_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,   32'h0, 32'h0},
    '{ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_OK,   32'h0, 32'h0},
    '{ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_MISS, 32'h0, 32'h0},
    '{ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK,   32'h0, 32'h0},
    '{ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,   32'hFFFF_FFFF, 32'h0},
    '{ACT_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 1'b1, ST_OK,
      32'hFFFF_FFFF, 32'hFFFF_FFFE},
    '{ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_MISS, 32'h0, 32'h0},
    '{ACT_INSERT, 32'h0000_1000, 32'hA5A5_A5A5, 1'b1, ST_OK,   32'h0, 32'h0},
    '{ACT_LOOKUP, 32'h0000_2000, 32'h0000_0000, 1'b0, ST_OK,   32'h0, 32'h0},
    '{ACT_SORT,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,   32'h0, 32'h0},
    '{ACT_LOOKUP, 32'h0000_1000, 32'h0000_0000, 1'b0, ST_OK,   32'h0, 32'h0},
    '{ACT_LOOKUP, 32'h0000_0FFF, 32'h0000_0000, 1'b0, ST_OK,   32'h0, 32'h0},
    '{ACT_INSERT, 32'h0000_1000, 32'h5A5A_5A5A, 1'b1, ST_OK,   32'h0, 32'h0},
    '{ACT_SORT,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,   32'h0, 32'h0},
    '{ACT_LOOKUP, 32'h0000_1000, 32'h0000_0000, 1'b0, ST_OK,   32'h0, 32'h0},
    '{ACT_INSERT, 32'h0000_0000, 32'hC3C3_C3C3, 1'b1, ST_OK,   32'h0, 32'h0},
    '{ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, ST_OK,   32'h0, 32'h0},
    '{ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, ST_OK,   32'h0, 32'h0},
    '{ACT_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,   32'h0, 32'h0},
    '{ACT_LOOKUP, 32'h0000_1000, 32'h0000_0000, 1'b1, ST_MISS, 32'h0, 32'h0},
    '{ACT_SORT,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,   32'h0, 32'h0}
  };

  // DUT signals, all inputs known from time zero.
  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start_i    = 1'b0;
  logic [1:0]        action_i   = ACT_INSERT;
  logic [DATA_W-1:0] address_i  = '0;
  logic [DATA_W-1:0] name_ref_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [1:0]        status_o;
  logic [DATA_W-1:0] found_name_o;
  logic [DATA_W-1:0] offset_o;

  // Shadow copy of the symbol table kept by the predictor.
  logic [DATA_W-1:0] shadow_start [DEPTH];
  logic [DATA_W-1:0] shadow_name  [DEPTH];
  int                shadow_count = 0;

  symbol_answer_t answers_due [$];
  symbol_answer_t check_want;

  int cycle_cnt    = 0;
  int beats_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int n_insert = 0, n_full = 0, n_sort = 0, n_clear = 0, n_hit = 0, n_miss = 0;
  bit idle_on = 1'b1;

  sorted_symbol_range_lookup_unit #(
    .TABLE_DEPTH (DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .address_i    (address_i),
    .name_ref_i   (name_ref_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_name_o (found_name_o),
    .offset_o     (offset_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Watchdog: a hung sequencer or a lost result ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers still due",
               cycle_cnt, answers_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Predictor: applies one command to the shadow table and returns its answer.
  // Sort is a stable ascending bubble sort; names travel with their starts.
  // Lookup takes the first stored pair with start[k] <= addr < start[k+1].
  task automatic predict_symbol_lookup(input action_e act, input logic [DATA_W-1:0] addr,
                                       input logic [DATA_W-1:0] name,
                                       output symbol_answer_t ans);
    logic [DATA_W-1:0] tmp_start, tmp_name;
    ans = '{status: ST_OK, name: '0, offset: '0};
    case (act)
      ACT_INSERT: begin
        if (shadow_count >= DEPTH) begin
          ans.status = ST_FULL;
          n_full++;
        end else begin
          shadow_start[shadow_count] = addr;
          shadow_name[shadow_count]  = name;
          shadow_count++;
          n_insert++;
        end
      end
      ACT_SORT: begin
        for (int pass = 0; pass + 1 < shadow_count; pass++) begin
          for (int k = 0; k + 1 < shadow_count - pass; k++) begin
            if (shadow_start[k] > shadow_start[k+1]) begin
              tmp_start         = shadow_start[k];
              tmp_name          = shadow_name[k];
              shadow_start[k]   = shadow_start[k+1];
              shadow_name[k]    = shadow_name[k+1];
              shadow_start[k+1] = tmp_start;
              shadow_name[k+1]  = tmp_name;
            end
          end
        end
        n_sort++;
      end
      ACT_LOOKUP: begin
        ans.status = ST_MISS;
        for (int k = 0; k + 1 < shadow_count; k++) begin
          if (addr >= shadow_start[k] && addr < shadow_start[k+1]) begin
            ans.status = ST_OK;
            ans.name   = shadow_name[k];
            ans.offset = addr - shadow_start[k];
            break;
          end
        end
        if (ans.status == ST_OK) n_hit++;
        else                     n_miss++;
      end
      default: begin
        shadow_count = 0;
        n_clear++;
      end
    endcase
  endtask

  // One command beat: hold start until the unit takes it, then queue its answer.
  // Returns at the accepting edge with start still high.
  task automatic send_cmd(input action_e act, input logic [DATA_W-1:0] addr,
                          input logic [DATA_W-1:0] name);
    symbol_answer_t ans;
    start_i    <= 1'b1;
    action_i   <= act;
    address_i  <= addr;
    name_ref_i <= name;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_symbol_lookup(act, addr, name, ans);
    answers_due.push_back(ans);
    beats_sent++;
  endtask

  // Sender gap: start low, junk on the command fields.
  task automatic hold_off(input int cycles);
    start_i    <= 1'b0;
    action_i   <= 2'($urandom);
    address_i  <= $urandom;
    name_ref_i <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if (idle_on && beats_sent < DIRECTED_N + RANDOM_BEATS - QUIET_BEATS &&
        $urandom_range(0, 3) == 0)
      hold_off($urandom_range(1, 11));
  endtask

  // Sender stops until every queued answer has come back.
  task automatic drain_answers();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  // Entry start: fully random, clustered near a base, or from a tiny set so
  // that equal starts and empty ranges show up. Extremes now and then.
  function automatic logic [DATA_W-1:0] pick_entry_addr(input int mode,
                                                       input logic [DATA_W-1:0] base);
    if ($urandom_range(0, 15) == 0)
      return ($urandom_range(0, 1) != 0) ? '1 : '0;
    case (mode)
      0:       return $urandom;
      1:       return base + $urandom_range(0, 255);
      default: return 32'($urandom_range(0, 3) * 16);
    endcase
  endfunction

  // Lookup address aimed at the shadow table: inside a range, on its edges,
  // at the last start, or anywhere.
  function automatic logic [DATA_W-1:0] pick_probe_addr();
    int                idx;
    logic [DATA_W-1:0] lo, hi;
    if (shadow_count < 2 || $urandom_range(0, 9) == 0)
      return $urandom;
    idx = $urandom_range(0, shadow_count - 2);
    lo  = shadow_start[idx];
    hi  = shadow_start[idx+1];
    case ($urandom_range(0, 4))
      0:       return (hi > lo) ? lo + ($urandom % (hi - lo)) : lo;
      1:       return lo;
      2:       return lo - 1;
      3:       return hi - 1;
      default: return shadow_start[shadow_count-1] + $urandom_range(0, 1);
    endcase
  endfunction

  // Well-formed session: clear, fill, sort, probe; sometimes extra inserts
  // after the sort so later probes scan an unsorted tail.
  task automatic run_table_session();
    int                n_entries, n_probes, addr_mode;
    logic [DATA_W-1:0] base;
    if ($urandom_range(0, 5) != 0) begin
      send_cmd(ACT_CLEAR, $urandom, $urandom);
      maybe_idle();
    end
    // mostly short tables; now and then past capacity to hit the full case
    n_entries = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(2, 20);
    addr_mode = $urandom_range(0, 2);
    base      = $urandom;
    repeat (n_entries) begin
      send_cmd(ACT_INSERT, pick_entry_addr(addr_mode, base), $urandom);
      maybe_idle();
    end
    if ($urandom_range(0, 7) != 0) begin
      send_cmd(ACT_SORT, $urandom, $urandom);
      maybe_idle();
    end
    n_probes = $urandom_range(3, 12);
    repeat (n_probes) begin
      send_cmd(ACT_LOOKUP, pick_probe_addr(), $urandom);
      maybe_idle();
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat (2) begin
        send_cmd(ACT_INSERT, pick_entry_addr(addr_mode, base), $urandom);
        maybe_idle();
      end
      repeat (3) begin
        send_cmd(ACT_LOOKUP, pick_probe_addr(), $urandom);
        maybe_idle();
      end
    end
  endtask

  // Noise: any command, any fields.
  task automatic run_noise();
    repeat ($urandom_range(5, 15)) begin
      send_cmd(action_e'($urandom_range(0, 3)), $urandom, $urandom);
      maybe_idle();
    end
  endtask

  // Result checker. Outputs are sampled mid-cycle, so the strobe seen here is
  // the one the next rising edge takes, with no race against the sender.
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat %0d: status %0d name %h offset %h",
                   results_seen, status_o, found_name_o, offset_o);
      end else begin
        check_want = answers_due.pop_front();
        if (status_o !== check_want.status || found_name_o !== check_want.name ||
            offset_o !== check_want.offset) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch at result beat %0d: want %0d/%h/%h got %0d/%h/%h",
                     results_seen, check_want.status, check_want.name,
                     check_want.offset, status_o, found_name_o, offset_o);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows. A typed answer replaces the predicted one just queued.
    for (int r = 0; r < DIRECTED_N; r++) begin
      send_cmd(DIRECTED_ROWS[r].act, DIRECTED_ROWS[r].addr, DIRECTED_ROWS[r].name);
      if (DIRECTED_ROWS[r].typed)
        answers_due[answers_due.size()-1] = '{status: DIRECTED_ROWS[r].status,
                                              name:   DIRECTED_ROWS[r].found,
                                              offset: DIRECTED_ROWS[r].offset};
      maybe_idle();
    end
    drain_answers();

    // Random part: mostly well-formed sessions, some noise, some full pauses.
    // Pauses stop in the final back-to-back stretch.
    while (beats_sent < DIRECTED_N + RANDOM_BEATS) begin
      idle_on = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: run_table_session();
        7, 8:                run_noise();
        default: begin
          if (beats_sent < DIRECTED_N + RANDOM_BEATS - QUIET_BEATS)
            drain_answers();
        end
      endcase
    end

    drain_answers();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("ran %0d beats in %0d cycles: %0d inserts, %0d refused as full, %0d sorts, %0d clears",
             beats_sent, cycle_cnt, n_insert, n_full, n_sort, n_clear);
    $display("lookups: %0d hits, %0d misses; %0d results checked, %0d mismatches",
             n_hit, n_miss, results_seen, mismatches);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
